/* sv/atb_pkg.sv */
package atb_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SET_REL = 3'd1,
    OP_SET_ABS = 3'd2,
    OP_CANCEL  = 3'd3,
    OP_READ    = 3'd4
  } atb_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_WALK_END,
    ST_READ,
    ST_FINISH
  } atb_state_e;

  localparam int unsigned FireWidth = 8;
  localparam int unsigned RemWidth  = 16;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  alarm_id;
    logic [15:0] start_value;
    logic [15:0] cycle_value;
  } atb_in_t;

  typedef struct packed {
    logic [FireWidth-1:0] fire_mask;
    logic [RemWidth-1:0]  remaining_ticks;
  } atb_out_t;

endpackage

/* sv/atb_ram.sv */
module atb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/atb_ctrl.sv */
module atb_ctrl #(
  parameter int unsigned ALARM_COUNT = 8,
  parameter int unsigned TICK_BITS   = 16,
  localparam int unsigned IW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1,
  localparam int unsigned DW = 2 * TICK_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  atb_pkg::atb_in_t    in_data_i,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output atb_pkg::atb_out_t   res_data_o,
  output logic                mem_we_o,
  output logic [IW-1:0]       mem_waddr_o,
  output logic [DW-1:0]       mem_wdata_o,
  output logic                mem_re_o,
  output logic [IW-1:0]       mem_raddr_o,
  input  logic [DW-1:0]       mem_rdata_i
);

  import atb_pkg::*;

  atb_state_e state_q, state_d;

  logic [TICK_BITS-1:0]   tick_q, tick_d;
  logic [ALARM_COUNT-1:0] vld_q, vld_d;
  logic [IW-1:0]          rd_idx_q, rd_idx_d;
  logic [IW-1:0]          wr_idx_q, wr_idx_d;
  logic                   wr_pend_q, wr_pend_d;
  logic                   rd_ok_q, rd_ok_d;
  logic [FireWidth-1:0]   fire_q, fire_d;
  logic [RemWidth-1:0]    rem_q, rem_d;

  logic                   in_accept;
  atb_op_e                op;
  logic                   id_ok;
  logic [IW-1:0]          id_addr;
  logic [TICK_BITS-1:0]   start_v, cycle_v, tick_inc;
  logic [TICK_BITS-1:0]   cur_cnt, cur_per, dec_cnt, new_cnt;
  logic                   expire;
  logic                   last_idx;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign op = atb_op_e'(in_data_i.op);
  assign id_ok = ({29'b0, in_data_i.alarm_id} < 32'(ALARM_COUNT));
  assign id_addr = IW'(in_data_i.alarm_id);
  assign start_v = TICK_BITS'(in_data_i.start_value);
  assign cycle_v = TICK_BITS'(in_data_i.cycle_value);
  assign tick_inc = tick_q + TICK_BITS'(1);
  assign last_idx = (rd_idx_q == IW'(ALARM_COUNT - 1));

  // entry never written reads as zero
  assign cur_cnt = rd_ok_q ? mem_rdata_i[TICK_BITS-1:0] : '0;
  assign cur_per = rd_ok_q ? mem_rdata_i[DW-1:TICK_BITS] : '0;
  assign dec_cnt = cur_cnt - TICK_BITS'(1);
  assign expire  = (cur_cnt != '0) && (dec_cnt == '0);
  assign new_cnt = expire ? cur_per : ((cur_cnt != '0) ? dec_cnt : cur_cnt);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (op == OP_TICK) begin
            state_d = ST_WALK;
          end else if (op == OP_READ) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        if (last_idx) begin
          state_d = ST_WALK_END;
        end
      end
      ST_WALK_END: state_d = ST_FINISH;
      ST_READ:     state_d = ST_FINISH;
      ST_FINISH: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    tick_d      = tick_q;
    vld_d       = vld_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    wr_pend_d   = wr_pend_q;
    rd_ok_d     = rd_ok_q;
    fire_d      = fire_q;
    rem_d       = rem_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = id_addr;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = id_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          fire_d    = '0;
          rem_d     = '0;
          rd_idx_d  = '0;
          wr_pend_d = 1'b0;
          case (op)
            OP_TICK: begin
              tick_d = (tick_inc == '0) ? TICK_BITS'(1) : tick_inc;
            end
            OP_SET_REL: begin
              mem_we_o    = id_ok;
              mem_wdata_o = {cycle_v, start_v};
            end
            OP_SET_ABS: begin
              mem_we_o    = id_ok;
              mem_wdata_o = {cycle_v, start_v - tick_q};
            end
            OP_CANCEL: begin
              mem_we_o    = id_ok;
              mem_wdata_o = '0;
            end
            OP_READ: begin
              mem_re_o = id_ok;
              rd_ok_d  = id_ok && vld_q[id_addr];
            end
            default: begin
            end
          endcase
          if (mem_we_o) begin
            vld_d[id_addr] = 1'b1;
          end
        end
      end
      ST_WALK, ST_WALK_END: begin
        // read entry k while entry k-1 is written back
        if (state_q == ST_WALK) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_idx_q;
          rd_ok_d     = vld_q[rd_idx_q];
          wr_idx_d    = rd_idx_q;
          wr_pend_d   = 1'b1;
          rd_idx_d    = rd_idx_q + IW'(1);
        end
        if (wr_pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wr_idx_q;
          mem_wdata_o = {cur_per, new_cnt};
          vld_d[wr_idx_q] = 1'b1;
          for (int j = 0; j < FireWidth; j++) begin
            if (j < ALARM_COUNT && wr_idx_q == IW'(j) && expire) begin
              fire_d[j] = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        rem_d = RemWidth'(cur_cnt);
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tick_q    <= TICK_BITS'(1);
      vld_q     <= '0;
      rd_idx_q  <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tick_q    <= tick_d;
      vld_q     <= vld_d;
      rd_idx_q  <= rd_idx_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q <= wr_idx_d;
    rd_ok_q  <= rd_ok_d;
    fire_q   <= fire_d;
    rem_q    <= rem_d;
  end

  assign res_valid_o = (state_q == ST_FINISH);
  assign res_data_o  = '{fire_mask: fire_q, remaining_ticks: rem_q};

endmodule

/* sv/alarm_timer_bank_core.sv */
// channel | valid     | stall      | payload
// in      | in_valid_i | in_stall_o | in_data_i  (atb_in_t)
// out     | out_valid_o| out_stall_i| out_data_o (atb_out_t)
//
// one beat in, one beat out; items are handled one at a time
// tick: walks the alarm ram from entry 0 up to ALARM_COUNT - 1 between accept and result
//   (one read and one write back per cycle)
// set, cancel and unused ops go from idle straight to the result, read passes a read state
// reset gives counter 1, all alarms zero (per-entry valid bits, no sweep)
// a result waiting in the output register does not block the next accept
module alarm_timer_bank_core #(
  parameter int unsigned ALARM_COUNT = 8,
  parameter int unsigned TICK_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  atb_pkg::atb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output atb_pkg::atb_out_t out_data_o
);

  import atb_pkg::*;

  localparam int unsigned IW = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
  localparam int unsigned DW = 2 * TICK_BITS;

  // alarm ram: {reload period, remaining count} per entry
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  logic     res_valid;
  logic     res_take;
  atb_out_t res_data;

  logic     out_valid_q, out_valid_d;
  atb_out_t out_q;

  atb_ram #(
    .WIDTH(DW),
    .DEPTH(ALARM_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  atb_ctrl #(
    .ALARM_COUNT(ALARM_COUNT),
    .TICK_BITS  (TICK_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_data_o (res_data),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  // output register: load when empty or being drained this cycle
  assign res_take    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_take || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* tb/sv/alarm_bank_checker.sv */
`timescale 1ns / 100ps

module alarm_bank_checker #(
  parameter int unsigned ALARM_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  atb_pkg::atb_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  atb_pkg::atb_out_t out_data_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o
);

  import atb_pkg::*;

  // keeps a runaway failure from flooding the log
  localparam int unsigned ReportCap = 100;

  logic [RemWidth-1:0] alarm_left   [ALARM_COUNT];
  logic [RemWidth-1:0] alarm_period [ALARM_COUNT];
  logic [RemWidth-1:0] tick_count;
  atb_out_t            due_results [$];
  int unsigned         mismatches = 0;

  // advances the alarm bank by one command and returns the beat it must produce
  function automatic atb_out_t apply_command(input atb_in_t cmd);
    atb_out_t res;
    res = '0;
    case (cmd.op)
      OP_TICK: begin
        tick_count = tick_count + 1'b1;
        if (tick_count == '0) tick_count = RemWidth'(1);
        for (int i = 0; i < ALARM_COUNT; i++) begin
          if (alarm_left[i] != '0) begin
            alarm_left[i] = alarm_left[i] - 1'b1;
            if (alarm_left[i] == '0) begin
              if (i < FireWidth) res.fire_mask[i] = 1'b1;
              alarm_left[i] = alarm_period[i];
            end
          end
        end
      end
      OP_SET_REL: begin
        if (cmd.alarm_id < ALARM_COUNT) begin
          alarm_left[cmd.alarm_id]   = cmd.start_value;
          alarm_period[cmd.alarm_id] = cmd.cycle_value;
        end
      end
      OP_SET_ABS: begin
        if (cmd.alarm_id < ALARM_COUNT) begin
          alarm_left[cmd.alarm_id]   = cmd.start_value - tick_count;
          alarm_period[cmd.alarm_id] = cmd.cycle_value;
        end
      end
      OP_CANCEL: begin
        if (cmd.alarm_id < ALARM_COUNT) begin
          alarm_left[cmd.alarm_id]   = '0;
          alarm_period[cmd.alarm_id] = '0;
        end
      end
      OP_READ: begin
        if (cmd.alarm_id < ALARM_COUNT) res.remaining_ticks = alarm_left[cmd.alarm_id];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    atb_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ALARM_COUNT; i++) begin
        alarm_left[i]   = '0;
        alarm_period[i] = '0;
      end
      tick_count = RemWidth'(1);
      due_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          if (mismatches < ReportCap) $error("result beat with nothing pending: %h", out_data_i);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (out_data_i.fire_mask !== want.fire_mask) begin
            if (mismatches < ReportCap)
              $error("fire_mask: expected %h, got %h", want.fire_mask, out_data_i.fire_mask);
            mismatches++;
          end
          if (out_data_i.remaining_ticks !== want.remaining_ticks) begin
            if (mismatches < ReportCap)
              $error("remaining_ticks: expected %h, got %h", want.remaining_ticks,
                     out_data_i.remaining_ticks);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) due_results.push_back(apply_command(in_data_i));
    end
    pending_o        <= due_results.size();
    mismatch_count_o <= mismatches;
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import atb_pkg::*;

  localparam int unsigned AlarmCount  = 8;
  // the limit leaves room for a correct run, even with the long hold-off
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned RandomItems = 250;
  localparam int unsigned HoldCycles  = 400;
  // op codes the block must treat as no-ops
  localparam logic [2:0]  OpSpareFirst = 3'd5;
  localparam logic [2:0]  OpSpareMid   = 3'd6;
  localparam logic [2:0]  OpSpareLast  = 3'd7;

  // who idles: slow sink, slow source, or nobody
  typedef enum logic [1:0] {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FULL
  } pace_e;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  atb_in_t  in_data   = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  atb_out_t out_data;

  int unsigned mismatch_count;
  int unsigned pending;

  pace_e       pace          = PACE_SLOW_SINK;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  // counter value as the block sees it, used only to aim absolute sets
  logic [15:0] tick_now      = 16'd1;

  alarm_timer_bank_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  alarm_bank_checker #(
    .ALARM_COUNT(AlarmCount)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("alarm_timer_bank_core: mismatch");
    $finish;
  end

  // result side pacing, plus the long hold-off that backs the block up
  always @(posedge clk) begin : sink_pacing
    int unsigned stall_pct;
    stall_pct = (pace == PACE_SLOW_SINK) ? 67 : (pace == PACE_SLOW_SOURCE) ? 9 : 0;
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic atb_in_t make_cmd(input logic [2:0] op, input logic [2:0] id,
                                       input logic [15:0] first, input logic [15:0] period);
    atb_in_t cmd;
    cmd.op          = op;
    cmd.alarm_id    = id;
    cmd.start_value = first;
    cmd.cycle_value = period;
    return cmd;
  endfunction

  // mostly short counts and periods so alarms really fire, wide values now and then
  function automatic atb_in_t random_command();
    int unsigned roll;
    logic [2:0]  op;
    logic [15:0] first;
    logic [15:0] period;
    roll   = $urandom_range(99);
    first  = 16'($urandom);
    period = 16'($urandom);
    if (roll < 42) begin
      op = OP_TICK;
    end else if (roll < 58) begin
      op = OP_SET_REL;
      if ($urandom_range(99) < 85) first = 16'($urandom_range(0, 24));
    end else if (roll < 68) begin
      op = OP_SET_ABS;
      // aim just ahead of the counter, sometimes right on it
      if ($urandom_range(99) < 85) first = tick_now + 16'($urandom_range(0, 24));
    end else if (roll < 73) begin
      op = OP_CANCEL;
    end else if (roll < 94) begin
      op = OP_READ;
    end else begin
      op = 3'($urandom_range(OpSpareFirst, OpSpareLast));
    end
    if (op == OP_SET_REL || op == OP_SET_ABS) begin
      roll = $urandom_range(99);
      if (roll < 40) period = '0;
      else if (roll < 85) period = 16'($urandom_range(1, 16));
    end
    return make_cmd(op, 3'($urandom_range(AlarmCount - 1)), first, period);
  endfunction

  // offers one beat, holds it until taken, then maybe leaves a gap
  task automatic issue(input atb_in_t cmd);
    int unsigned idle_pct;
    idle_pct = (pace == PACE_SLOW_SINK) ? 9 : (pace == PACE_SLOW_SOURCE) ? 67 : 0;
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    if (cmd.op == OP_TICK) begin
      tick_now = tick_now + 1'b1;
      if (tick_now == '0) tick_now = 16'd1;
    end
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // source goes quiet until every predicted beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fresh bank, one-shot, zero increment, absolute on the counter,
    // absolute one behind the counter (wraps to full count), cancel, spare ops
    pace = PACE_SLOW_SINK;
    issue(make_cmd(OP_READ, 3'd0, 16'hFFFF, 16'hFFFF));
    issue(make_cmd(OP_SET_REL, 3'd0, 16'd1, 16'd0));
    issue(make_cmd(OP_TICK, 3'd7, 16'h0000, 16'h0000));
    issue(make_cmd(OP_TICK, 3'd0, 16'hFFFF, 16'hFFFF));
    issue(make_cmd(OP_SET_REL, 3'd7, 16'd0, 16'd5));
    issue(make_cmd(OP_READ, 3'd7, 16'h0000, 16'h0000));
    issue(make_cmd(OP_SET_REL, 3'd1, 16'd2, 16'd3));
    issue(make_cmd(OP_SET_REL, 3'd2, 16'hFFFF, 16'hFFFF));
    issue(make_cmd(OP_SET_ABS, 3'd3, tick_now, 16'd4));
    issue(make_cmd(OP_READ, 3'd3, 16'h0000, 16'h0000));
    issue(make_cmd(OP_SET_ABS, 3'd4, tick_now - 1'b1, 16'd0));
    issue(make_cmd(OP_READ, 3'd4, 16'h0000, 16'h0000));
    issue(make_cmd(OP_SET_ABS, 3'd5, tick_now + 16'd2, 16'd1));
    issue(make_cmd(OP_SET_REL, 3'd6, 16'd1, 16'd0));
    issue(make_cmd(OP_SET_REL, 3'd7, 16'd1, 16'hFFFF));
    repeat (3) issue(make_cmd(OP_TICK, 3'd0, 16'h0000, 16'h0000));
    issue(make_cmd(OP_READ, 3'd1, 16'h0000, 16'h0000));
    issue(make_cmd(OP_READ, 3'd5, 16'h0000, 16'h0000));
    issue(make_cmd(OP_CANCEL, 3'd2, 16'hFFFF, 16'hFFFF));
    issue(make_cmd(OP_READ, 3'd2, 16'h0000, 16'h0000));
    issue(make_cmd(OpSpareFirst, 3'd7, 16'hFFFF, 16'hFFFF));
    issue(make_cmd(OpSpareMid, 3'd0, 16'h0000, 16'h0000));
    issue(make_cmd(OpSpareLast, 3'd5, 16'hA5A5, 16'h5A5A));

    // random, slow sink
    repeat (RandomItems) issue(random_command());
    drain();

    // random, slow source
    pace = PACE_SLOW_SOURCE;
    repeat (RandomItems) issue(random_command());
    drain();

    // random, full rate, sink holds off for a long stretch so the block backs up
    pace = PACE_FULL;
    hold_requests++;
    repeat (RandomItems) issue(random_command());
    drain();

    // full-width counts armed, mixed traffic, then absolute sets around the counter
    issue(make_cmd(OP_SET_REL, 3'd6, 16'hFFFF, 16'h0000));
    issue(make_cmd(OP_SET_REL, 3'd7, 16'd999, 16'd1000));
    repeat (60) issue(random_command());
    issue(make_cmd(OP_SET_ABS, 3'd0, 16'h0000, 16'd2));
    issue(make_cmd(OP_SET_ABS, 3'd1, tick_now, 16'd0));
    issue(make_cmd(OP_SET_ABS, 3'd2, 16'hFFFF, 16'd3));
    issue(make_cmd(OP_READ, 3'd0, 16'h0000, 16'h0000));
    issue(make_cmd(OP_READ, 3'd1, 16'h0000, 16'h0000));
    issue(make_cmd(OP_READ, 3'd2, 16'h0000, 16'h0000));
    issue(make_cmd(OP_READ, 3'd6, 16'h0000, 16'h0000));
    issue(make_cmd(OP_READ, 3'd7, 16'h0000, 16'h0000));
    drain();

    // a tick walk is the longest job, leave room for a stray late beat
    repeat (24) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("alarm_timer_bank_core: match");
    end else begin
      $display("alarm_timer_bank_core: mismatch");
    end
    $finish;
  end

endmodule

/* alarm_timer_bank_core.f */
sv/atb_pkg.sv
sv/atb_ram.sv
sv/atb_ctrl.sv
sv/alarm_timer_bank_core.sv
tb/sv/alarm_bank_checker.sv
tb/sv/tb.sv
